FILE: rtl/tlar_pkg.sv
`timescale 1ns / 1ps

package tlar_pkg;

	// Input coordinate ports and the part of them that carries the value.
	localparam int IN_W       = 16;
	localparam int COORD_BITS = 16;

	// Datapath widths; all but ACC_W and Q_BITS are derived from the coordinate width.
	localparam int EDGE_W    = COORD_BITS + 1;
	localparam int PROD_W    = 2 * EDGE_W;
	localparam int MAG_W     = 2 * COORD_BITS + 1;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SQRT_BITS = 2 * COORD_BITS + 3;
	localparam int RAD_W     = 2 * SQRT_BITS;
	localparam int REM_W     = SQRT_BITS + 2;
	localparam int L1_W      = MAG_W + 2;
	localparam int ACC_W     = 56;
	localparam int Q_BITS    = 16;
	localparam int CNT_W     = $clog2(SQRT_BITS);

	typedef struct packed {
		logic load;
		logic mul;
		logic norm;
		logic sqr;
		logic sum;
		logic sqrt_step;
		logic acc;
		logic dset;
		logic dchk;
		logic div_step;
		logic out_load;
	} tlar_cmd_t;

	typedef struct packed {
		logic last;
	} tlar_sts_t;

	// Sign-extends the low COORD_BITS of a port value to an edge-wide operand.
	function automatic logic signed [EDGE_W-1:0] sext_coord(input logic [IN_W-1:0] v);
		logic signed [EDGE_W-1:0] r;
		r = {{(EDGE_W - COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]};
		return r;
	endfunction

endpackage

FILE: rtl/triangle_l1_area_ratio.sv
`timescale 1ns / 1ps

// Mesh area-quality accumulator. Each word on the input is one triangle; the block forms the
// edge cross product, adds its L1 norm and its floor Euclidean length into two saturating
// 56-bit sums, and on the word marked last_triangle delivers one result word: quality is
// (L1 sum / L2 sum - 1) as unsigned Q0.16 truncated, zero_area flags an all-zero mesh, and
// both sums are cleared. A triangle occupies the block through the bit-serial integer square
// root; the last triangle of a mesh also passes through the serial divider and the output
// load. The next triangle is taken while a result word still waits on the output.
module triangle_l1_area_ratio (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlar_pkg::IN_W-1:0]      ax,
	input  logic [tlar_pkg::IN_W-1:0]      ay,
	input  logic [tlar_pkg::IN_W-1:0]      az,
	input  logic [tlar_pkg::IN_W-1:0]      bx,
	input  logic [tlar_pkg::IN_W-1:0]      by_coord,
	input  logic [tlar_pkg::IN_W-1:0]      bz,
	input  logic [tlar_pkg::IN_W-1:0]      cx,
	input  logic [tlar_pkg::IN_W-1:0]      cy,
	input  logic [tlar_pkg::IN_W-1:0]      cz,
	input  logic                           last_triangle,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tlar_pkg::Q_BITS-1:0]    quality,
	output logic                           zero_area
);
	import tlar_pkg::*;

	tlar_cmd_t cmd;
	tlar_sts_t sts;

	tlar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlar_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ax            (ax),
		.ay            (ay),
		.az            (az),
		.bx            (bx),
		.by_coord      (by_coord),
		.bz            (bz),
		.cx            (cx),
		.cy            (cy),
		.cz            (cz),
		.last_triangle (last_triangle),
		.cmd           (cmd),
		.sts           (sts),
		.quality       (quality),
		.zero_area     (zero_area)
	);

endmodule

FILE: rtl/tlar_ctrl.sv
`timescale 1ns / 1ps

module tlar_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tlar_pkg::tlar_sts_t  sts,
	output tlar_pkg::tlar_cmd_t  cmd
);
	import tlar_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_NORM = 4'd2;
	localparam logic [3:0] S_SQR  = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_SQRT = 4'd5;
	localparam logic [3:0] S_ACC  = 4'd6;
	localparam logic [3:0] S_DSET = 4'd7;
	localparam logic [3:0] S_DCHK = 4'd8;
	localparam logic [3:0] S_DIV  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_NORM;
			end
			S_NORM: begin
				cmd.norm = 1'b1;
				state_d  = S_SQR;
			end
			S_SQR: begin
				cmd.sqr = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? S_DSET : S_IDLE;
			end
			S_DSET: begin
				cmd.dset = 1'b1;
				state_d  = S_DCHK;
			end
			S_DCHK: begin
				cmd.dchk = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// The result waits here until the output register is free.
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SUM) begin
				cnt_q <= CNT_W'(SQRT_BITS - 1);
			end else if (state_q == S_DCHK) begin
				cnt_q <= CNT_W'(Q_BITS - 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/tlar_dp.sv
`timescale 1ns / 1ps

module tlar_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tlar_pkg::IN_W-1:0]      ax,
	input  logic [tlar_pkg::IN_W-1:0]      ay,
	input  logic [tlar_pkg::IN_W-1:0]      az,
	input  logic [tlar_pkg::IN_W-1:0]      bx,
	input  logic [tlar_pkg::IN_W-1:0]      by_coord,
	input  logic [tlar_pkg::IN_W-1:0]      bz,
	input  logic [tlar_pkg::IN_W-1:0]      cx,
	input  logic [tlar_pkg::IN_W-1:0]      cy,
	input  logic [tlar_pkg::IN_W-1:0]      cz,
	input  logic                           last_triangle,
	input  tlar_pkg::tlar_cmd_t            cmd,
	output tlar_pkg::tlar_sts_t            sts,
	output logic [tlar_pkg::Q_BITS-1:0]    quality,
	output logic                           zero_area
);
	import tlar_pkg::*;

	logic signed [EDGE_W-1:0] e1_q [3];
	logic signed [EDGE_W-1:0] e2_q [3];
	logic                     last_q;
	logic signed [PROD_W-1:0] prod_q [6];
	logic [MAG_W-1:0]         mag_q [3];
	logic [L1_W-1:0]          l1_tri_q;
	logic [SQ_W-1:0]          sq_q [3];

	logic [RAD_W-1:0]         rad_q;
	logic [REM_W-1:0]         rem_q;
	logic [SQRT_BITS-1:0]     root_q;
	logic [REM_W+1:0]         rem_sh;
	logic [REM_W+1:0]         trial;
	logic                     sq_ge;

	logic [ACC_W-1:0]         l1_sum_q;
	logic [ACC_W-1:0]         l2_sum_q;
	logic [ACC_W:0]           l1_add;
	logic [ACC_W:0]           l2_add;

	logic [ACC_W-1:0]         rem_d_q;
	logic [ACC_W-1:0]         dvs_q;
	logic [Q_BITS-1:0]        quo_q;
	logic                     zero_q;
	logic                     le_q;
	logic                     sat_q;
	logic [ACC_W:0]           div_sh;
	logic [ACC_W:0]           div_diff;
	logic                     div_ge;

	logic [Q_BITS-1:0]        quality_q;
	logic                     zero_area_q;

	logic signed [PROD_W:0]   n_diff [3];

	assign sts.last  = last_q;
	assign quality   = quality_q;
	assign zero_area = zero_area_q;

	// Cross product components n = e1 x e2, before taking magnitudes.
	assign n_diff[0] = PROD_W'(prod_q[0]) - PROD_W'(prod_q[1]);
	assign n_diff[1] = PROD_W'(prod_q[2]) - PROD_W'(prod_q[3]);
	assign n_diff[2] = PROD_W'(prod_q[4]) - PROD_W'(prod_q[5]);

	// Each step takes two radicand bits and settles one bit of the root.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = (REM_W + 2)'({root_q, 2'b01});
	assign sq_ge  = (rem_sh >= trial);

	assign l1_add = {1'b0, l1_sum_q} + (ACC_W + 1)'(l1_tri_q);
	assign l2_add = {1'b0, l2_sum_q} + (ACC_W + 1)'(root_q);

	// One quotient bit per step of the restoring division.
	assign div_sh   = {rem_d_q, 1'b0};
	assign div_diff = div_sh - {1'b0, dvs_q};
	assign div_ge   = (div_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e1_q[0] <= sext_coord(bx) - sext_coord(ax);
			e1_q[1] <= sext_coord(by_coord) - sext_coord(ay);
			e1_q[2] <= sext_coord(bz) - sext_coord(az);
			e2_q[0] <= sext_coord(cx) - sext_coord(ax);
			e2_q[1] <= sext_coord(cy) - sext_coord(ay);
			e2_q[2] <= sext_coord(cz) - sext_coord(az);
			last_q  <= last_triangle;
		end
		if (cmd.mul) begin
			prod_q[0] <= e1_q[1] * e2_q[2];
			prod_q[1] <= e1_q[2] * e2_q[1];
			prod_q[2] <= e1_q[2] * e2_q[0];
			prod_q[3] <= e1_q[0] * e2_q[2];
			prod_q[4] <= e1_q[0] * e2_q[1];
			prod_q[5] <= e1_q[1] * e2_q[0];
		end
		if (cmd.norm) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= n_diff[k][PROD_W] ? MAG_W'(-n_diff[k]) : MAG_W'(n_diff[k]);
			end
		end
		if (cmd.sqr) begin
			for (int k = 0; k < 3; k++) begin
				sq_q[k] <= SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
			end
			l1_tri_q <= L1_W'(mag_q[0]) + L1_W'(mag_q[1]) + L1_W'(mag_q[2]);
		end
		if (cmd.sum) begin
			rad_q  <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rem_q  <= sq_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[SQRT_BITS-2:0], sq_ge};
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
		end
		if (cmd.dset) begin
			zero_q  <= (l2_sum_q == '0);
			le_q    <= (l1_sum_q <= l2_sum_q);
			rem_d_q <= l1_sum_q - l2_sum_q;
			dvs_q   <= l2_sum_q;
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_d_q <= div_ge ? ACC_W'(div_diff) : ACC_W'(div_sh);
			quo_q   <= {quo_q[Q_BITS-2:0], div_ge};
		end
		if (cmd.dchk) begin
			// A ratio of two or more cannot be shown and clips to all ones.
			sat_q <= (rem_d_q >= dvs_q);
		end
		if (cmd.out_load) begin
			if (zero_q || le_q) begin
				quality_q <= '0;
			end else if (sat_q) begin
				quality_q <= '1;
			end else begin
				quality_q <= quo_q;
			end
			zero_area_q <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_sum_q <= '0;
			l2_sum_q <= '0;
		end else if (cmd.acc) begin
			l1_sum_q <= l1_add[ACC_W] ? '1 : l1_add[ACC_W-1:0];
			l2_sum_q <= l2_add[ACC_W] ? '1 : l2_add[ACC_W-1:0];
		end else if (cmd.dset) begin
			l1_sum_q <= '0;
			l2_sum_q <= '0;
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF   = 5;
	localparam int RAND_ITEMS = 2000;
	localparam int HOLD_AT    = 8000;
	localparam int HOLD_LEN   = 500;
	localparam int QUIET_LO   = 40000;
	localparam int QUIET_HI   = 55000;
	localparam int DRAIN_CYC  = 80;
	localparam logic [63:0] SUM_MAX = (64'd1 << tlar_pkg::ACC_W) - 64'd1;

	// Coordinates in port order: ax ay az bx by bz cx cy cz, i.e. a, b, c with x, y, z each.
	typedef struct packed {
		logic [8:0][tlar_pkg::IN_W-1:0] xyz;
		logic                            last;
		logic                            typed;
		logic [tlar_pkg::Q_BITS-1:0]     q;
		logic                            z;
	} tri_row_t;

	typedef struct packed {
		logic [tlar_pkg::Q_BITS-1:0] q;
		logic                        z;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [tlar_pkg::IN_W-1:0] ax = '0, ay = '0, az = '0;
	logic [tlar_pkg::IN_W-1:0] bx = '0, by_coord = '0, bz = '0;
	logic [tlar_pkg::IN_W-1:0] cx = '0, cy = '0, cz = '0;
	logic last_triangle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [tlar_pkg::Q_BITS-1:0] quality;
	logic zero_area;

	logic [63:0] mesh_l1_sum = '0;
	logic [63:0] mesh_l2_sum = '0;
	score_t pending_scores[$];
	tri_row_t dir_rows[$];

	int err_count = 0;
	int tris_taken = 0;
	int meshes_done = 0;
	int zero_meshes = 0;
	int full_scale = 0;
	int input_stalls = 0;

	triangle_l1_area_ratio DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ax(ax),
		.ay(ay),
		.az(az),
		.bx(bx),
		.by_coord(by_coord),
		.bz(bz),
		.cx(cx),
		.cy(cy),
		.cz(cz),
		.last_triangle(last_triangle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quality(quality),
		.zero_area(zero_area)
	);

	initial begin
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	initial begin
		#10_000_000;
		$display("Timeout: %0d score words still outstanding", pending_scores.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// Accumulates one triangle into the mesh sums; on the last one it yields the score word.
	function automatic bit score_triangle(input logic [8:0][tlar_pkg::IN_W-1:0] v,
			input logic last, output score_t sc);
		longint p[9];
		longint e1[3], e2[3], n[3];
		logic [127:0] mag, sumsq, root, trial, rem;
		logic [63:0] l1, l2, t;
		for (int k = 0; k < 9; k++)
			p[k] = longint'($signed(v[k][tlar_pkg::COORD_BITS-1:0]));
		for (int k = 0; k < 3; k++) begin
			e1[k] = p[3 + k] - p[k];
			e2[k] = p[6 + k] - p[k];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		l1 = '0;
		sumsq = '0;
		for (int k = 0; k < 3; k++) begin
			mag = (n[k] < 0) ? 128'(-n[k]) : 128'(n[k]);
			l1 += mag[63:0];
			sumsq += mag * mag;
		end
		root = '0;
		for (int b = tlar_pkg::SQRT_BITS - 1; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sumsq)
				root = trial;
		end
		l2 = root[63:0];
		t = mesh_l1_sum + l1;
		mesh_l1_sum = (t > SUM_MAX) ? SUM_MAX : t;
		t = mesh_l2_sum + l2;
		mesh_l2_sum = (t > SUM_MAX) ? SUM_MAX : t;
		sc = '0;
		if (!last)
			return 1'b0;
		if (mesh_l2_sum == 0) begin
			sc.z = 1'b1;
		end else if (mesh_l1_sum > mesh_l2_sum) begin
			rem = 128'(mesh_l1_sum - mesh_l2_sum);
			if (rem >= 128'(mesh_l2_sum))
				sc.q = '1;
			else
				sc.q = 16'(((rem << tlar_pkg::Q_BITS) / 128'(mesh_l2_sum)));
		end
		mesh_l1_sum = '0;
		mesh_l2_sum = '0;
		return 1'b1;
	endfunction

	function automatic tri_row_t mk_row(input int a0, a1, a2, b0, b1, b2, c0, c1, c2,
			input bit last, input bit typed = 1'b0, input int q = 0, input bit z = 1'b0);
		tri_row_t r;
		r.xyz[0] = 16'(a0);
		r.xyz[1] = 16'(a1);
		r.xyz[2] = 16'(a2);
		r.xyz[3] = 16'(b0);
		r.xyz[4] = 16'(b1);
		r.xyz[5] = 16'(b2);
		r.xyz[6] = 16'(c0);
		r.xyz[7] = 16'(c1);
		r.xyz[8] = 16'(c2);
		r.last = last;
		r.typed = typed;
		r.q = 16'(q);
		r.z = z;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic put_triangle(input tri_row_t r, input bit idle_ok);
		score_t sc;
		while (idle_ok && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		{ax, ay, az} <= {r.xyz[0], r.xyz[1], r.xyz[2]};
		{bx, by_coord, bz} <= {r.xyz[3], r.xyz[4], r.xyz[5]};
		{cx, cy, cz} <= {r.xyz[6], r.xyz[7], r.xyz[8]};
		last_triangle <= r.last;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
			if (in_stall)
				input_stalls++;
		end while (in_stall);
		tris_taken++;
		if (score_triangle(r.xyz, r.last, sc)) begin
			if (r.typed) begin
				sc.q = r.q;
				sc.z = r.z;
			end
			pending_scores.push_back(sc);
			meshes_done++;
			if (sc.z)
				zero_meshes++;
			if (sc.q == '1)
				full_scale++;
		end
		@(negedge clk);
	endtask

	// Result side: random stalls, one long hold-off, and a stretch with no stall.
	initial begin
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
				out_stall <= 1'b1;
			else if (cyc >= QUIET_LO && cyc < QUIET_HI)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		score_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				report_mismatch("unexpected score word, quality", quality, -1);
			end else begin
				want = pending_scores.pop_front();
				if (quality !== want.q)
					report_mismatch("quality", quality, want.q);
				if (zero_area !== want.z)
					report_mismatch("zero_area", zero_area, want.z);
			end
		end
	end

	initial begin
		tri_row_t r;
		int mesh_len, kind, d[3];
		bit idle_ok;

		// Single-triangle meshes whose score is obvious.
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0, 0));
		// Normal (1,1,0): L1 is 2 and the floor root is 1, so the ratio hits full scale.
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 1, -1, 0, 1, 1, 16'hFFFF, 0));
		dir_rows.push_back(mk_row(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768, 1, 1, 0, 0));
		// A collinear triangle and a repeated vertex add nothing to either sum.
		dir_rows.push_back(mk_row(1, 2, 3, 2, 4, 6, 3, 6, 9, 0));
		dir_rows.push_back(mk_row(5, -5, 7, 5, -5, 7, 100, 200, -300, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 1, 1, 0, 1));
		dir_rows.push_back(mk_row(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768, 0));
		dir_rows.push_back(mk_row(-32768, 32767, 0, 32767, -32768, 32767,
			0, -32768, -32768, 1));
		dir_rows.push_back(mk_row(-32768, -32768, -32768, 32767, 32767, -32768,
			-32768, 32767, 32767, 1));
		dir_rows.push_back(mk_row(-1, -1, -1, 32767, -32768, 1, -32768, 32767, -1, 1));
		dir_rows.push_back(mk_row(256, 0, 0, 0, 256, 0, 0, 0, 256, 0));
		dir_rows.push_back(mk_row(-128, 64, 32, 300, -17, 5, 11, 900, -450, 0));
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(1000, -2000, 3000, -4000, 5000, -6000, 7000, 8000, -9000, 1));
		dir_rows.push_back(mk_row(3, 1, 4, 1, 5, 9, 2, 6, 5, 1));
		dir_rows.push_back(mk_row(32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767, 1));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			put_triangle(dir_rows[i], 1'b1);

		while (tris_taken < RAND_ITEMS) begin
			mesh_len = ($urandom_range(99) < 10) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			for (int t = 0; t < mesh_len; t++) begin
				kind = $urandom_range(99);
				for (int k = 0; k < 9; k++) begin
					if (kind < 70)
						r.xyz[k] = 16'($urandom());
					else
						r.xyz[k] = 16'($urandom_range(0, 511) - 256);
				end
				if (kind >= 90) begin
					// Degenerate: either a repeated vertex or three points on a line.
					for (int k = 0; k < 3; k++)
						d[k] = $urandom_range(0, 2000) - 1000;
					for (int k = 0; k < 3; k++) begin
						r.xyz[3 + k] = (kind < 95) ? r.xyz[k] : 16'(r.xyz[k] + d[k]);
						r.xyz[6 + k] = 16'(r.xyz[k] + 2 * d[k]);
					end
				end
				r.last = (t == mesh_len - 1);
				r.typed = 1'b0;
				r.q = '0;
				r.z = 1'b0;
				idle_ok = !(tris_taken >= 600 && tris_taken < 900);
				put_triangle(r, idle_ok);
			end
		end
		in_valid <= 1'b0;

		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Run covered %0d triangles in %0d meshes: %0d zero-area, %0d full-scale scores.",
			tris_taken, meshes_done, zero_meshes, full_scale);
		$display("Input was held back for %0d cycles, including one long output hold-off.",
			input_stalls);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", err_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
